[rtl/srr_pkg.sv]
`default_nettype none
package srr_pkg;

   localparam int WINDOW_SIZE_DEF = 6;
   localparam int SEQ_SPACE_DEF   = 12;

   localparam int WORD_W   = 32;
   localparam int WIDE_W   = 64;
   localparam int PAYLOAD_W = 2 * WIDE_W + WORD_W;

   localparam logic [WORD_W-1:0] ACK_PAD_SUM = 32'd960;

   localparam logic KIND_DELIVERY = 1'b0;
   localparam logic KIND_ACK      = 1'b1;

endpackage
`default_nettype wire

[rtl/srr_req_if.sv]
`default_nettype none
interface srr_req_if import srr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] sequence_number;
   logic signed [WORD_W-1:0] ack_field;
   logic signed [WORD_W-1:0] packet_checksum;
   logic        [WIDE_W-1:0] payload_low;
   logic        [WIDE_W-1:0] payload_mid;
   logic        [WORD_W-1:0] payload_high;

   modport source (
      output valid, sequence_number, ack_field, packet_checksum,
             payload_low, payload_mid, payload_high,
      input  ready
   );
   modport sink (
      input  valid, sequence_number, ack_field, packet_checksum,
             payload_low, payload_mid, payload_high,
      output ready
   );
endinterface
`default_nettype wire

[rtl/srr_rsp_if.sv]
`default_nettype none
interface srr_rsp_if import srr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic        [WIDE_W-1:0] out_payload_low;
   logic        [WIDE_W-1:0] out_payload_mid;
   logic        [WORD_W-1:0] out_payload_high;
   logic signed [WORD_W-1:0] ack_number;
   logic signed [WORD_W-1:0] ack_checksum;
   logic                     last;

   modport source (
      output valid, kind, out_payload_low, out_payload_mid, out_payload_high,
             ack_number, ack_checksum, last,
      input  ready
   );
   modport sink (
      input  valid, kind, out_payload_low, out_payload_mid, out_payload_high,
             ack_number, ack_checksum, last,
      output ready
   );
endinterface
`default_nettype wire

[rtl/selective_repeat_receiver_core.sv]
// Steps: a request is taken in idle, its checksum is summed over the five payload words
// (four bytes a cycle), then one decide state chooses the ack and whether to hold or deliver.
// Then the in-order delivery and each held entry, read from the payload memory, go out
// through the output register, then the ack; a result that waits there stalls the block,
// and a new request is taken only once the ack of the last has been registered.
// Reset: synchronous; resets expected sequence and window bounds, clears all held flags.
`default_nettype none
module selective_repeat_receiver_core import srr_pkg::*; #(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
   parameter int SEQ_SPACE   = SEQ_SPACE_DEF
) (
   input  wire        clock,
   input  wire        reset,
   srr_req_if.sink    req,
   srr_rsp_if.source  rsp
);

   localparam int SEQ_W   = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
   localparam int EXTRA_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int WE_RST  = (WINDOW_SIZE - 1) % SEQ_SPACE;
   localparam int CHUNKS  = PAYLOAD_W / WORD_W;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_SUM       = 7'b0000010,
      ST_DECIDE    = 7'b0000100,
      ST_DLV_FIRST = 7'b0001000,
      ST_CHAIN     = 7'b0010000,
      ST_DLV_HELD  = 7'b0100000,
      ST_ACK       = 7'b1000000
   } state_type;

   state_type                state_ff, state_in;
   logic [SEQ_W-1:0]         exp_ff, exp_in;
   logic [SEQ_W-1:0]         we_ff, we_in;
   logic [SEQ_W-1:0]         prev_ff, prev_in;
   logic [SEQ_SPACE-1:0]     held_ff, held_in;
   logic [EXTRA_W-1:0]       extra_ff, extra_in;
   logic [2:0]               cnt_ff, cnt_in;
   logic signed [WORD_W-1:0] seq_ff, seq_in;
   logic [WORD_W-1:0]        csum_ff, csum_in;
   logic [WORD_W-1:0]        sum_ff, sum_in;
   logic [WORD_W-1:0]        ack_ff, ack_in;
   logic [PAYLOAD_W-1:0]     pay_ff, pay_in;
   logic [PAYLOAD_W-1:0]     shift_ff, shift_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_kind_ff, rsp_kind_in;
   logic [PAYLOAD_W-1:0]     rsp_pay_ff, rsp_pay_in;
   logic [WORD_W-1:0]        rsp_ack_ff, rsp_ack_in;
   logic [WORD_W-1:0]        rsp_csum_ff, rsp_csum_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [PAYLOAD_W-1:0]     held_mem [SEQ_SPACE];
   logic [PAYLOAD_W-1:0]     rd_data_ff;

   logic                     out_free;
   logic [WORD_W-1:0]        chunk_sum;
   logic [SEQ_W-1:0]         seq_idx;
   logic                     in_range;
   logic                     in_win;
   logic                     below_exp;
   logic                     good;
   logic                     hold_wr;
   logic                     chain_go;
   logic                     rd_en;
   logic                     dlv_fire;

   function automatic logic [SEQ_W-1:0] inc_mod(input logic [SEQ_W-1:0] x);
      return (x == SEQ_W'(SEQ_SPACE - 1)) ? '0 : x + 1'b1;
   endfunction

   assign out_free = !rsp_valid_ff || rsp.ready;

   assign chunk_sum = WORD_W'(signed'(shift_ff[7:0]))   + WORD_W'(signed'(shift_ff[15:8]))
                    + WORD_W'(signed'(shift_ff[23:16])) + WORD_W'(signed'(shift_ff[31:24]));

   assign seq_idx   = seq_ff[SEQ_W-1:0];
   assign in_range  = !seq_ff[WORD_W-1] && (seq_ff[WORD_W-2:0] < (WORD_W-1)'(SEQ_SPACE));
   assign in_win    = in_range && ((exp_ff <= we_ff) ? (seq_idx >= exp_ff && seq_idx <= we_ff)
                                                     : (seq_idx >= exp_ff || seq_idx <= we_ff));
   assign below_exp = seq_ff[WORD_W-1] || (seq_ff[WORD_W-2:0] < (WORD_W-1)'(exp_ff));
   assign good      = (sum_ff == csum_ff);
   assign hold_wr   = (state_ff == ST_DECIDE) && good && in_win
                    && (seq_idx != exp_ff) && !held_ff[seq_idx];
   assign chain_go  = (extra_ff < EXTRA_W'(WINDOW_SIZE - 1)) && held_ff[exp_ff];
   assign rd_en     = (state_ff == ST_CHAIN) && chain_go;
   assign dlv_fire  = out_free && ((state_ff == ST_DLV_FIRST) || (state_ff == ST_DLV_HELD));

   assign req.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      we_in        = we_ff;
      prev_in      = prev_ff;
      held_in      = held_ff;
      extra_in     = extra_ff;
      cnt_in       = cnt_ff;
      seq_in       = seq_ff;
      csum_in      = csum_ff;
      sum_in       = sum_ff;
      ack_in       = ack_ff;
      pay_in       = pay_ff;
      shift_in     = shift_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_ack_in   = rsp_ack_ff;
      rsp_csum_in  = rsp_csum_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               seq_in   = req.sequence_number;
               csum_in  = req.packet_checksum;
               sum_in   = req.sequence_number + req.ack_field;
               pay_in   = {req.payload_high, req.payload_mid, req.payload_low};
               shift_in = {req.payload_high, req.payload_mid, req.payload_low};
               cnt_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in   = sum_ff + chunk_sum;
            shift_in = shift_ff >> WORD_W;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == 3'(CHUNKS - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (good && in_win) begin
               ack_in = WORD_W'(seq_idx);
            end else if (good && below_exp) begin
               ack_in = seq_ff;
            end else begin
               ack_in = WORD_W'(prev_ff);
            end
            if (hold_wr) begin
               held_in[seq_idx] = 1'b1;
            end
            state_in = (good && in_win && seq_idx == exp_ff) ? ST_DLV_FIRST : ST_ACK;
         end
         ST_DLV_FIRST, ST_DLV_HELD: begin
            if (dlv_fire) begin
               rsp_valid_in    = 1'b1;
               rsp_kind_in     = KIND_DELIVERY;
               rsp_pay_in      = (state_ff == ST_DLV_FIRST) ? pay_ff : rd_data_ff;
               rsp_ack_in      = '0;
               rsp_csum_in     = '0;
               rsp_last_in     = 1'b0;
               held_in[exp_ff] = 1'b0;
               exp_in          = inc_mod(exp_ff);
               we_in           = inc_mod(we_ff);
               prev_in         = inc_mod(prev_ff);
               extra_in        = (state_ff == ST_DLV_FIRST) ? '0 : extra_ff + 1'b1;
               state_in        = ST_CHAIN;
            end
         end
         ST_CHAIN: begin
            // read of the next held entry is issued here, data lands next cycle
            state_in = chain_go ? ST_DLV_HELD : ST_ACK;
         end
         ST_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACK;
               rsp_pay_in   = '0;
               rsp_ack_in   = ack_ff;
               rsp_csum_in  = ack_ff + ACK_PAD_SUM;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         exp_ff       <= '0;
         we_ff        <= SEQ_W'(WE_RST);
         prev_ff      <= SEQ_W'(SEQ_SPACE - 1);
         held_ff      <= '0;
         extra_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exp_ff       <= exp_in;
         we_ff        <= we_in;
         prev_ff      <= prev_in;
         held_ff      <= held_in;
         extra_ff     <= extra_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff      <= seq_in;
      csum_ff     <= csum_in;
      sum_ff      <= sum_in;
      ack_ff      <= ack_in;
      pay_ff      <= pay_in;
      shift_ff    <= shift_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_pay_ff  <= rsp_pay_in;
      rsp_ack_ff  <= rsp_ack_in;
      rsp_csum_ff <= rsp_csum_in;
      rsp_last_ff <= rsp_last_in;
   end

   // writes happen only in the decide cycle and reads only in the chain, so one
   // entry is never written and read in the same cycle
   always_ff @(posedge clock) begin
      if (hold_wr) begin
         held_mem[seq_idx] <= pay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= held_mem[exp_ff];
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.kind             = rsp_kind_ff;
   assign rsp.out_payload_low  = rsp_pay_ff[WIDE_W-1:0];
   assign rsp.out_payload_mid  = rsp_pay_ff[2*WIDE_W-1:WIDE_W];
   assign rsp.out_payload_high = rsp_pay_ff[PAYLOAD_W-1:2*WIDE_W];
   assign rsp.ack_number       = rsp_ack_ff;
   assign rsp.ack_checksum     = rsp_csum_ff;
   assign rsp.last             = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_last_is_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_kind_ff == KIND_ACK)))
      else $error("last flag does not match ack kind");

   a_prev_tracks_exp: assert property (@(posedge clock) disable iff (reset)
      (prev_ff == SEQ_W'(SEQ_SPACE - 1)) ? (exp_ff == '0) : (exp_ff == prev_ff + 1'b1))
      else $error("previous sequence out of step with expected sequence");

   a_read_only_held: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> held_ff[exp_ff])
      else $error("payload memory read of an entry not held");

   a_exp_moves_on_delivery: assert property (@(posedge clock) disable iff (reset)
      (exp_ff != $past(exp_ff)) |-> ($past(reset) || $past(dlv_fire)))
      else $error("expected sequence moved without a delivery");
`endif

endmodule
`default_nettype wire

[tb/sv/srr_receive_checker.sv]
`timescale 1ns / 1ps
module srr_receive_checker import srr_pkg::*; (
   input  wire  clock,
   input  wire  reset,
   srr_req_if   req,
   srr_rsp_if   rsp,
   output int   mismatches,
   output int   results_owed
);

   typedef struct packed {
      logic                 kind;
      logic [PAYLOAD_W-1:0] payload;
      logic [WORD_W-1:0]    ack_number;
      logic [WORD_W-1:0]    ack_checksum;
      logic                 last;
   } receiver_result_type;

   receiver_result_type  owed_q[$];
   int                   next_seq;
   bit                   held_flag    [SEQ_SPACE_DEF];
   logic [PAYLOAD_W-1:0] held_payload [SEQ_SPACE_DEF];

   // payload bytes count as signed, the total wraps at 32 bits
   function automatic logic [WORD_W-1:0] payload_total(input logic [PAYLOAD_W-1:0] pay);
      logic [WORD_W-1:0] total;
      total = '0;
      for (int i = 0; i < PAYLOAD_W / 8; i++)
         total = total + {{(WORD_W-8){pay[8*i+7]}}, pay[8*i +: 8]};
      return total;
   endfunction

   function automatic void owe(input logic kind, input logic [PAYLOAD_W-1:0] pay,
                               input logic [WORD_W-1:0] ack_no);
      receiver_result_type r;
      r.kind         = kind;
      r.payload      = pay;
      r.ack_number   = ack_no;
      r.ack_checksum = (kind == KIND_ACK) ? ack_no + ACK_PAD_SUM : '0;
      r.last         = (kind == KIND_ACK);
      owed_q.push_back(r);
   endfunction

   function automatic void predict_packet(input logic [WORD_W-1:0] seq,
                                          input logic [WORD_W-1:0] ackf,
                                          input logic [WORD_W-1:0] carried,
                                          input logic [PAYLOAD_W-1:0] pay);
      logic [WORD_W-1:0] ack_no;
      int                s;
      int                extra;
      bit                win_hit;
      ack_no  = (next_seq + SEQ_SPACE_DEF - 1) % SEQ_SPACE_DEF;
      win_hit = 1'b0;
      s       = 0;
      if (seq + ackf + payload_total(pay) == carried) begin
         if (!seq[WORD_W-1] && seq < SEQ_SPACE_DEF) begin
            s       = int'(seq);
            win_hit = ((s - next_seq + SEQ_SPACE_DEF) % SEQ_SPACE_DEF) < WINDOW_SIZE_DEF;
         end
         if (win_hit) begin
            if (s == next_seq) begin
               owe(KIND_DELIVERY, pay, '0);
               held_flag[s] = 1'b0;
               next_seq     = (next_seq + 1) % SEQ_SPACE_DEF;
               extra        = 0;
               // release the run of held packets that now follows in order
               while (extra < WINDOW_SIZE_DEF - 1 && held_flag[next_seq]) begin
                  owe(KIND_DELIVERY, held_payload[next_seq], '0);
                  held_flag[next_seq] = 1'b0;
                  next_seq = (next_seq + 1) % SEQ_SPACE_DEF;
                  extra++;
               end
            end else if (!held_flag[s]) begin
               held_flag[s]    = 1'b1;
               held_payload[s] = pay;
            end
            ack_no = s;
         end else if (seq[WORD_W-1] || seq < next_seq) begin
            // a negative number is below the window too, so echo it
            ack_no = seq;
         end
      end
      owe(KIND_ACK, '0, ack_no);
   endfunction

   function automatic void compare_field(input string name, input logic [WIDE_W-1:0] want,
                                         input logic [WIDE_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      receiver_result_type want;
      if (reset) begin
         next_seq   = 0;
         mismatches = 0;
         owed_q.delete();
         foreach (held_flag[i]) held_flag[i] = 1'b0;
      end else begin
         if (req.valid && req.ready)
            predict_packet(req.sequence_number, req.ack_field, req.packet_checksum,
                           {req.payload_high, req.payload_mid, req.payload_low});
         if (rsp.valid && rsp.ready) begin
            if (owed_q.size() == 0) begin
               mismatches++;
               $display("%0t ns: result expected none, got kind %b ack %h last %b",
                        $time, rsp.kind, rsp.ack_number, rsp.last);
            end else begin
               want = owed_q.pop_front();
               compare_field("kind", WIDE_W'(want.kind), WIDE_W'(rsp.kind));
               compare_field("payload low", want.payload[WIDE_W-1:0], rsp.out_payload_low);
               compare_field("payload mid", want.payload[2*WIDE_W-1:WIDE_W],
                             rsp.out_payload_mid);
               compare_field("payload high", WIDE_W'(want.payload[PAYLOAD_W-1:2*WIDE_W]),
                             WIDE_W'(rsp.out_payload_high));
               compare_field("ack number", WIDE_W'(want.ack_number),
                             WIDE_W'(unsigned'(rsp.ack_number)));
               compare_field("ack checksum", WIDE_W'(want.ack_checksum),
                             WIDE_W'(unsigned'(rsp.ack_checksum)));
               compare_field("last", WIDE_W'(want.last), WIDE_W'(rsp.last));
            end
         end
      end
      results_owed = owed_q.size();
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import srr_pkg::*;

   typedef enum int {NOISE_CORRUPT, NOISE_STRAY, NOISE_REPEAT} noise_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   results_owed;
   int   packets_sent = 0;
   int   results_taken = 0;
   bit   steady_send = 1'b0;

   srr_req_if req_ch ();
   srr_rsp_if rsp_ch ();

   selective_repeat_receiver_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   srr_receive_checker watch (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .mismatches   (mismatches),
      .results_owed (results_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [WORD_W-1:0] packet_sum(input logic [WORD_W-1:0] seq,
                                                    input logic [WORD_W-1:0] ackf,
                                                    input logic [PAYLOAD_W-1:0] pay);
      logic [WORD_W-1:0] total;
      total = seq + ackf;
      for (int i = 0; i < PAYLOAD_W / 8; i++)
         total = total + {{(WORD_W-8){pay[8*i+7]}}, pay[8*i +: 8]};
      return total;
   endfunction

   function automatic logic [PAYLOAD_W-1:0] random_payload();
      return {$urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   task automatic send_packet(input logic [WORD_W-1:0] seq, input logic [WORD_W-1:0] ackf,
                              input logic [PAYLOAD_W-1:0] pay, input bit intact);
      int                gap;
      logic [WORD_W-1:0] carried;
      gap     = steady_send ? 0 : $urandom_range(0, 14);
      carried = packet_sum(seq, ackf, pay);
      if (!intact) carried = carried + $urandom_range(1, 32'hFFFF_FFFF);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.sequence_number <= seq;
      req_ch.ack_field       <= ackf;
      req_ch.packet_checksum <= carried;
      req_ch.payload_low     <= pay[WIDE_W-1:0];
      req_ch.payload_mid     <= pay[2*WIDE_W-1:WIDE_W];
      req_ch.payload_high    <= pay[PAYLOAD_W-1:2*WIDE_W];
      req_ch.valid           <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      packets_sent++;
   endtask

   // result side: random stalls, one long hold-off to back the block up
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      while (reset) @(negedge clock);
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_taken++;
            @(negedge clock);
            if (results_taken == 40)
               stall = 400;
            else if ((results_taken / 32) % 3 == 0)
               stall = 0;
            else
               stall = $urandom_range(0, 14);
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(negedge clock);
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      int        base;
      int        n;
      int        pick;
      int        swap;
      int        order [WINDOW_SIZE_DEF];
      noise_type noise;
      req_ch.valid           = 1'b0;
      req_ch.sequence_number = '0;
      req_ch.ack_field       = '0;
      req_ch.packet_checksum = '0;
      req_ch.payload_low     = '0;
      req_ch.payload_mid     = '0;
      req_ch.payload_high    = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corrupt packet, then sequence numbers outside the space
      send_packet(0, $urandom, random_payload(), 1'b0);
      send_packet(32'hFFFF_FFFF, $urandom, random_payload(), 1'b1);
      send_packet(32'h8000_0000, $urandom, random_payload(), 1'b1);
      send_packet(32'h7FFF_FFFF, $urandom, random_payload(), 1'b1);
      send_packet(SEQ_SPACE_DEF, $urandom, random_payload(), 1'b1);
      // hold out of order, repeat a held one, then release the whole window
      send_packet(5, 32'h7FFF_FFFF, {PAYLOAD_W{1'b1}}, 1'b1);
      send_packet(5, 32'h8000_0000, '0, 1'b1);
      send_packet(3, $urandom, {20{8'h80}}, 1'b1);
      send_packet(1, $urandom, {20{8'h7F}}, 1'b1);
      send_packet(2, $urandom, random_payload(), 1'b1);
      send_packet(4, $urandom, random_payload(), 1'b1);
      send_packet(0, 0, '0, 1'b1);
      send_packet(0, $urandom, random_payload(), 1'b1);
      send_packet(7, 0, random_payload(), 1'b1);
      send_packet(6, $urandom, random_payload(), 1'b1);
      send_packet(6, $urandom, random_payload(), 1'b0);

      base = 8;
      while (packets_sent < 220) begin
         n           = $urandom_range(1, WINDOW_SIZE_DEF);
         steady_send = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < n; i++) order[i] = (base + i) % SEQ_SPACE_DEF;
         for (int i = n - 1; i > 0; i--) begin
            pick        = $urandom_range(0, i);
            swap        = order[i];
            order[i]    = order[pick];
            order[pick] = swap;
         end
         for (int i = 0; i < n; i++) begin
            // noise must not touch a window slot not yet sent in this batch
            if ($urandom_range(0, 2) == 0) begin
               noise = noise_type'($urandom_range(0, 2));
               case (noise)
                  NOISE_CORRUPT:
                     send_packet($urandom_range(0, 1) ? $urandom : $urandom_range(0, 11),
                                 $urandom, random_payload(), 1'b0);
                  NOISE_STRAY:
                     send_packet($urandom_range(0, 1) ? ($urandom | 32'h8000_0000)
                                    : $urandom_range(SEQ_SPACE_DEF, 32'h7FFF_FFFF),
                                 $urandom, random_payload(), 1'b1);
                  default:
                     if (i > 0)
                        send_packet(order[$urandom_range(0, i - 1)], $urandom,
                                    random_payload(), 1'b1);
                     else
                        send_packet(order[0], $urandom, random_payload(), 1'b0);
               endcase
            end
            send_packet(order[i], $urandom, random_payload(), 1'b1);
         end
         base = (base + n) % SEQ_SPACE_DEF;
      end

      req_ch.valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (mismatches == 0)
         $display("selective_repeat_receiver_core verification clean");
      else
         $display("selective_repeat_receiver_core verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("selective_repeat_receiver_core verification failed");
      $finish;
   end

endmodule
